[rtl/ttlc_pkg.sv]
// Shared types and constants, hash constants among them, for the tiled texture LRU cache.
// No dependencies.
package ttlc_pkg;

   localparam int NUM_SETS_DEF = 256;
   localparam int NUM_WAYS_DEF = 4;

   localparam int OFS_W = 24;
   localparam int TW_W = 16;
   localparam int TAG_W = 24;
   localparam int CFG_W = 9;

   localparam logic [31:0] HASH_MUL = 32'h045d9f3b;
   localparam int HASH_SHIFT = 16;

   localparam logic CSR_BLOCK_WIDTH = 1'b0;
   localparam logic CSR_BLOCK_HEIGHT = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture a request
      logic div_start; // start a division
      logic [1:0] div_sel; // which division to run
      logic calc_tile; // start the tile multiply
      logic calc_tag;  // add the first block
      logic hash1;     // hash steps
      logic mod_mul;   // reciprocal multiply of the set reduction
      logic hash3;
      logic mod_sub;   // remainder of the set reduction
      logic hash5;
      logic rd_set;    // read the set
      logic wr_set;    // write back the set and register the result
      logic clr_step;  // clearing pass write
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic clr_last;
   } sts_type;

   localparam logic [1:0] DIV_ROW = 2'd0; // offset / width
   localparam logic [1:0] DIV_TPR = 2'd1; // (width + bw - 1) / bw
   localparam logic [1:0] DIV_RBH = 2'd2; // row / bh
   localparam logic [1:0] DIV_CBW = 2'd3; // col / bw

endpackage

[rtl/ttlc_divider.sv]
// Restoring divider, one quotient bit per cycle, 24-bit operands.
// No dependencies.
module ttlc_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [23:0] dividend,
   input  logic [23:0] divisor,
   output logic        done,
   output logic [23:0] quotient,
   output logic [23:0] remainder
);

   logic [23:0] quo_ff, quo_in;
   logic [23:0] rem_ff, rem_in;
   logic [23:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [24:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[23]} - {1'b0, dvs_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[24]) begin
            rem_in = trial[23:0];
            quo_in = {quo_ff[22:0], 1'b1};
         end else begin
            rem_in = {rem_ff[22:0], quo_ff[23]};
            quo_in = {quo_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd23) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

endmodule

[rtl/ttlc_datapath.sv]
// Address math, hash, set memory and LRU update of the texture cache.
// Depends on ttlc_pkg and ttlc_divider.
module ttlc_datapath #(
   parameter int NUM_SETS = ttlc_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS = ttlc_pkg::NUM_WAYS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ttlc_pkg::cmd_type         cmd,
   output ttlc_pkg::sts_type         sts,
   input  logic [ttlc_pkg::OFS_W-1:0] req_texel_offset,
   input  logic [ttlc_pkg::TW_W-1:0]  req_texture_width,
   input  logic [ttlc_pkg::TAG_W-1:0] req_texture_first_block,
   input  logic [ttlc_pkg::CFG_W-1:0] block_width,
   input  logic [ttlc_pkg::CFG_W-1:0] block_height,
   output logic                      hit
);

   localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int ENT_W = ttlc_pkg::TAG_W + 1;
   localparam int ROW_W = ENT_W * NUM_WAYS;
   localparam int MOD_L = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 0;
   // Reciprocal of the set count, rounded up, so that the quotient of any
   // 32-bit hash comes out exact after the shift.
   localparam logic [63:0] MOD_RECIP =
      ((64'd1 << (32 + MOD_L)) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS);

   logic [ROW_W-1:0] mem [NUM_SETS];

   logic [23:0] ofs_ff, ofs_in;
   logic [15:0] tw_ff, tw_in;
   logic [23:0] first_ff, first_in;
   logic [8:0]  bw_ff, bw_in;
   logic [8:0]  bh_ff, bh_in;
   logic [23:0] row_ff, col_ff, tpr_ff, rbh_ff, cbw_ff;
   logic [23:0] tile_ff;
   logic [23:0] tag_ff;
   logic [31:0] h_ff, h_in;
   logic [31:0] q_ff;
   logic [SET_W-1:0] set_ff;
   logic [SET_W-1:0] clr_ff;
   logic [ROW_W-1:0] rd_ff;
   logic hit_ff;

   logic        div_start;
   logic [23:0] div_a, div_b, div_q, div_r;
   logic        div_done;
   logic [47:0] prod;
   logic [63:0] hprod;
   logic [31:0] hmix;
   logic [64:0] qprod, qshift;
   logic [31:0] qn, hrem;

   ttlc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q),
      .remainder(div_r)
   );

   assign div_start = cmd.div_start;

   always_comb begin
      case (cmd.div_sel)
         ttlc_pkg::DIV_ROW: begin
            div_a = ofs_ff;
            div_b = {8'd0, tw_ff};
         end
         ttlc_pkg::DIV_TPR: begin
            div_a = {8'd0, tw_ff} + {15'd0, bw_ff} - 24'd1;
            div_b = {15'd0, bw_ff};
         end
         ttlc_pkg::DIV_RBH: begin
            div_a = row_ff;
            div_b = {15'd0, bh_ff};
         end
         default: begin
            div_a = col_ff;
            div_b = {15'd0, bw_ff};
         end
      endcase
   end

   always_comb begin
      ofs_in = req_texel_offset;
      tw_in = (req_texture_width == '0) ? 16'd1 : req_texture_width;
      first_in = req_texture_first_block;
      bw_in = (block_width == '0) ? 9'd1 : block_width;
      bh_in = (block_height == '0) ? 9'd1 : block_height;
   end

   assign prod = rbh_ff * tpr_ff;
   assign hmix = (h_ff >> ttlc_pkg::HASH_SHIFT) ^ h_ff;
   assign hprod = hmix * ttlc_pkg::HASH_MUL;

   // Set index as hash minus quotient times set count.
   assign qprod = {33'd0, h_ff} * {32'd0, MOD_RECIP[32:0]};
   assign qshift = qprod >> (32 + MOD_L);
   assign qn = q_ff * 32'(NUM_SETS);
   assign hrem = h_ff - qn;

   always_comb begin
      h_in = h_ff;
      if (cmd.calc_tag) h_in = {8'd0, tile_ff + first_ff};
      else if (cmd.hash1 || cmd.hash3) h_in = hprod[31:0];
      else if (cmd.hash5) h_in = hmix;
   end

   // LRU update: matched or last way drops out, entries above it shift down.
   logic [ENT_W-1:0] ent;
   logic [ROW_W-1:0] new_row;
   logic             found;
   always_comb begin
      ent = {1'b1, tag_ff};
      found = 1'b0;
      new_row = rd_ff;
      for (int i = 0; i < NUM_WAYS; i++) begin
         if (rd_ff[i*ENT_W +: ENT_W] == ent) found = 1'b1;
      end
      for (int i = NUM_WAYS - 1; i > 0; i--) begin
         logic stop;
         stop = 1'b0;
         for (int k = 0; k < i; k++) begin
            if (rd_ff[k*ENT_W +: ENT_W] == ent) stop = 1'b1;
         end
         if (!stop) new_row[i*ENT_W +: ENT_W] = rd_ff[(i-1)*ENT_W +: ENT_W];
      end
      new_row[0 +: ENT_W] = ent;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ofs_ff <= ofs_in;
         tw_ff <= tw_in;
         first_ff <= first_in;
         bw_ff <= bw_in;
         bh_ff <= bh_in;
      end
      if (div_done) begin
         case (cmd.div_sel)
            ttlc_pkg::DIV_ROW: begin
               row_ff <= div_q;
               col_ff <= div_r;
            end
            ttlc_pkg::DIV_TPR: tpr_ff <= div_q;
            ttlc_pkg::DIV_RBH: rbh_ff <= div_q;
            default: cbw_ff <= div_q;
         endcase
      end
      if (cmd.calc_tile) tile_ff <= prod[23:0] + cbw_ff;
      if (cmd.calc_tag) tag_ff <= tile_ff + first_ff;
      h_ff <= h_in;
      if (cmd.mod_mul) q_ff <= qshift[31:0];
      if (cmd.mod_sub) set_ff <= hrem[SET_W-1:0];
      if (cmd.rd_set) rd_ff <= mem[set_ff];
      if (cmd.wr_set) begin
         mem[set_ff] <= new_row;
         hit_ff <= found;
      end else if (cmd.clr_step) begin
         mem[clr_ff] <= '0;
      end
      if (reset) clr_ff <= '0;
      else if (cmd.clr_step) clr_ff <= clr_ff + SET_W'(1);
   end

   assign sts.div_done = div_done;
   assign sts.clr_last = (clr_ff == SET_W'(NUM_SETS - 1));
   assign hit = hit_ff;

endmodule

[rtl/ttlc_ctrl.sv]
// Sequencer for the texture cache: clearing pass, divisions, hash, set update.
// Depends on ttlc_pkg.
module ttlc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ttlc_pkg::cmd_type cmd,
   input  ttlc_pkg::sts_type sts
);

   typedef enum logic [13:0] {
      ST_CLEAR = 14'b00000000000001,
      ST_IDLE  = 14'b00000000000010,
      ST_DIV   = 14'b00000000000100,
      ST_WAIT  = 14'b00000000001000,
      ST_TILE  = 14'b00000000010000,
      ST_TAG   = 14'b00000000100000,
      ST_H1    = 14'b00000001000000,
      ST_MUL   = 14'b00000010000000,
      ST_H3    = 14'b00000100000000,
      ST_H5    = 14'b00001000000000,
      ST_RD    = 14'b00010000000000,
      ST_WR    = 14'b00100000000000,
      ST_OUT   = 14'b01000000000000,
      ST_SUB   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      cmd.div_sel = sel_ff;
      req_stall = 1'b1;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = rsp_valid_ff && rsp_stall;
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               sel_in = ttlc_pkg::DIV_ROW;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.div_done) begin
               if (sel_ff == ttlc_pkg::DIV_CBW) begin
                  state_in = ST_TILE;
               end else begin
                  sel_in = sel_ff + 2'd1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_TILE: begin
            cmd.calc_tile = 1'b1;
            state_in = ST_TAG;
         end
         ST_TAG: begin
            cmd.calc_tag = 1'b1;
            state_in = ST_H1;
         end
         ST_H1: begin
            cmd.hash1 = 1'b1;
            state_in = ST_H3;
         end
         ST_H3: begin
            cmd.hash3 = 1'b1;
            state_in = ST_H5;
         end
         ST_H5: begin
            cmd.hash5 = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mod_mul = 1'b1;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            cmd.mod_sub = 1'b1;
            state_in = ST_RD;
         end
         ST_RD: begin
            cmd.rd_set = 1'b1;
            state_in = ST_WR;
         end
         ST_WR: begin
            cmd.wr_set = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sel_ff <= ttlc_pkg::DIV_ROW;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/tiled_texture_lru_cache.sv]
// Tiled texture LRU cache: maps a texel to its global tile number, hashes it
// to a set and does a true-LRU lookup, answering hit or miss per request.
// A new request is taken only once the response to the last one has been
// issued, so requests do not overlap. Four serial divisions (row/column
// split, tiles per row, tile row and tile column) each run as a start step,
// one step per quotient bit and a done step. Then come the tile multiply,
// the tag add, three hash steps, two steps that reduce the hash to a set,
// and the set read, write and response. A stalled response holds off the
// next request. After reset a clearing pass over all NUM_SETS sets runs
// before requests are taken.
// Depends on ttlc_pkg, ttlc_ctrl and ttlc_datapath.
module tiled_texture_lru_cache #(
   parameter int NUM_SETS = ttlc_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS = ttlc_pkg::NUM_WAYS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ttlc_pkg::OFS_W-1:0] req_texel_offset,
   input  logic [ttlc_pkg::TW_W-1:0]  req_texture_width,
   input  logic [ttlc_pkg::TAG_W-1:0] req_texture_first_block,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_hit,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [ttlc_pkg::CFG_W-1:0] csr_data
);

   logic [ttlc_pkg::CFG_W-1:0] bw_ff, bh_ff;
   ttlc_pkg::cmd_type cmd;
   ttlc_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff <= 9'd8;
         bh_ff <= 9'd8;
      end else if (csr_valid) begin
         if (csr_index == ttlc_pkg::CSR_BLOCK_WIDTH) bw_ff <= csr_data;
         else bh_ff <= csr_data;
      end
   end

   ttlc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd),
      .sts      (sts)
   );

   ttlc_datapath #(
      .NUM_SETS(NUM_SETS),
      .NUM_WAYS(NUM_WAYS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_texel_offset       (req_texel_offset),
      .req_texture_width      (req_texture_width),
      .req_texture_first_block(req_texture_first_block),
      .block_width            (bw_ff),
      .block_height           (bh_ff),
      .hit                    (rsp_hit)
   );

endmodule
